FILE: design/progressive_pixel_accumulator_macros.svh
// Assertion macros for the progressive pixel accumulator.
`ifndef PROGRESSIVE_PIXEL_ACCUMULATOR_MACROS_SVH
`define PROGRESSIVE_PIXEL_ACCUMULATOR_MACROS_SVH
`ifndef SYNTH
`define PPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: design/ppa_pkg.sv
// Shared types and constants for the progressive pixel accumulator.
package ppa_pkg;
    localparam int PIXELS_DEF     = 65536;
    localparam int FRAME_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int CH             = 4;
    localparam int SUM_W          = 32;
    localparam int SAMP_W         = 16;
    localparam int IDX_W          = 16;
    localparam int PADDR_W        = 2;
    localparam logic [PADDR_W-1:0] REG_ACC_EN = 2'd0;

    typedef struct packed {
        logic [IDX_W-1:0]  pixel_index;
        logic [SAMP_W-1:0] red_sample;
        logic [SAMP_W-1:0] green_sample;
        logic [SAMP_W-1:0] blue_sample;
        logic [SAMP_W-1:0] alpha_sample;
        logic              end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] out_pixel_index;
        logic [31:0]      packed_color;
    } t_out_item;

    // Channel order: 0 red, 1 green, 2 blue, 3 alpha.
    typedef logic [CH-1:0][SAMP_W-1:0] t_samps;
    typedef logic [CH-1:0][SUM_W-1:0]  t_sums;

    typedef struct packed {
        logic en;
        logic valid;
    } t_flow;
endpackage

FILE: design/progressive_pixel_accumulator.sv
// Results are registered through the accumulator, the divider and the output register.
// Throughput: one request per cycle; the whole pipeline holds while the output waits.
// The divider resolves one quotient bit per stage, and the accumulator memory reads one entry as it writes another.
// Reset clears valid bits, sets the frame number to 1 and accumulation off.
// Accumulator memory is not cleared; frame one overwrites each entry.
module progressive_pixel_accumulator import ppa_pkg::*; #(
    parameter int PIXELS     = PIXELS_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_in_item           i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output t_out_item          o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    `include "progressive_pixel_accumulator_macros.svh"

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
    localparam logic [FRAME_BITS-1:0] FRAME_ONE = FRAME_BITS'(1);
    localparam logic [FRAC_BITS:0]    ONE_FIX   = (FRAC_BITS+1)'(1 << FRAC_BITS);

    logic                  r_acc_en;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_en, w_accept;
    t_flow                 w_flow;
    t_samps                w_samps;

    logic                  a_valid;
    logic [IDX_W-1:0]      a_idx;
    logic [FRAME_BITS-1:0] a_frame;
    logic [SUM_W-1:0]      a_limit;
    t_sums                 a_sums;

    logic                       d_valid;
    logic [IDX_W-1:0]           d_idx;
    logic [CH-1:0]              d_clamp;
    logic [CH-1:0][FRAC_BITS:0] d_quot;
    logic [CH-1:0][7:0]         w_bytes;

    assign w_en     = !r_out_valid || i_ready;
    assign w_accept = i_valid && w_en;
    assign o_ready  = w_en;
    assign w_flow   = '{en: w_en, valid: i_valid};
    assign w_samps  = {i_item.alpha_sample, i_item.blue_sample,
                       i_item.green_sample, i_item.red_sample};

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ACC_EN) ? {31'b0, r_acc_en} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_ACC_EN) begin
            r_acc_en <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_ONE;
        end else if (w_accept && i_item.end_of_frame) begin
            if (!r_acc_en) begin
                r_frame <= FRAME_ONE;
            end else if (r_frame != FRAME_MAX) begin
                r_frame <= r_frame + FRAME_ONE;
            end
        end
    end

    ppa_accum #(
        .PIXELS     (PIXELS),
        .FRAME_BITS (FRAME_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow),
        .i_idx   (i_item.pixel_index),
        .i_samps (w_samps),
        .i_first (r_frame == FRAME_ONE),
        .i_frame (r_frame),
        .o_valid (a_valid),
        .o_idx   (a_idx),
        .o_frame (a_frame),
        .o_limit (a_limit),
        .o_sums  (a_sums)
    );

    ppa_div #(
        .FRAME_BITS (FRAME_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{en: w_en, valid: a_valid}),
        .i_idx   (a_idx),
        .i_frame (a_frame),
        .i_limit (a_limit),
        .i_sums  (a_sums),
        .o_valid (d_valid),
        .o_idx   (d_idx),
        .o_clamp (d_clamp),
        .o_quot  (d_quot)
    );

    // Byte = (avg * 255) >> FRAC_BITS, with avg limited to 1.0.
    always_comb begin
        logic [FRAC_BITS:0]   avg;
        logic [FRAC_BITS+8:0] prod;
        for (int c = 0; c < CH; c++) begin
            avg        = d_clamp[c] ? ONE_FIX : d_quot[c];
            prod       = ((FRAC_BITS+9)'(avg) << 8) - (FRAC_BITS+9)'(avg);
            w_bytes[c] = prod[FRAC_BITS+7:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && d_valid) begin
            r_out.out_pixel_index <= d_idx;
            r_out.packed_color    <= w_bytes;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `PPA_ASSERT(a_frame_nonzero, i_clk, i_rst_n, r_frame != '0, "frame number reached zero")
    `PPA_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (r_out_valid && !i_ready) |-> !o_ready, "input taken while output stalled")
    `PPA_ASSERT(a_restart, i_clk, i_rst_n, (w_accept && i_item.end_of_frame && !r_acc_en) |=> (r_frame == FRAME_ONE), "frame did not restart")
    `PPA_ASSERT_RST(a_reset_frame, i_clk, !i_rst_n |=> (r_frame == FRAME_ONE && !r_out_valid), "reset state wrong")
endmodule

FILE: design/ppa_accum.sv
// Address reduction, accumulator memory and saturating read-modify-write; frame one overwrites the sum.
module ppa_accum import ppa_pkg::*; #(
    parameter int PIXELS     = PIXELS_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_flow                 i_flow,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_samps                i_samps,
    input  logic                  i_first,
    input  logic [FRAME_BITS-1:0] i_frame,
    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_idx,
    output logic [FRAME_BITS-1:0] o_frame,
    output logic [SUM_W-1:0]      o_limit,
    output t_sums                 o_sums
);
    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / PIXELS);
    localparam logic [SUM_W-1:0] LIM_MUL = SUM_W'((1 << FRAC_BITS) + 1);

    t_sums r_mem [PIXELS];
    t_sums r_rd;

    logic                  r0_v, r1_v, r2_v;
    logic [IDX_W-1:0]      r0_idx, r1_idx, r2_idx;
    t_samps                r0_samps, r1_samps;
    logic                  r0_first, r1_first;
    logic [FRAME_BITS-1:0] r0_frame, r1_frame, r2_frame;
    logic [SUM_W-1:0]      r0_limit, r1_limit, r2_limit;
    logic [IDX_W-1:0]      r0_q;
    logic [AW-1:0]         r1_addr;
    t_sums                 r2_sums;
    logic                  r_fwd_v;
    logic [AW-1:0]         r_fwd_addr;
    t_sums                 r_fwd_sums;

    logic [48:0] w_prod;
    logic [36:0] w_qp, w_r, w_rr;
    logic [AW-1:0] w_addr;
    t_sums w_old, n_sums;
    logic [SUM_W:0] w_add [CH];

    assign w_prod = 49'(i_idx) * 49'(RECIP);
    // The reciprocal estimate of the quotient is low by at most one.
    assign w_qp   = 37'(r0_q) * 37'(PIXELS);
    assign w_r    = 37'(r0_idx) - w_qp;
    assign w_rr   = (w_r >= 37'(PIXELS)) ? (w_r - 37'(PIXELS)) : w_r;
    assign w_addr = w_rr[AW-1:0];

    // The previous request writes on the same edge that this one reads.
    assign w_old = (r_fwd_v && r_fwd_addr == r1_addr) ? r_fwd_sums : r_rd;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_add[c] = 33'(w_old[c]) + 33'(r1_samps[c]);
            if (r1_first) begin
                n_sums[c] = SUM_W'(r1_samps[c]);
            end else if (w_add[c][SUM_W]) begin
                n_sums[c] = '1;
            end else begin
                n_sums[c] = w_add[c][SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else if (i_flow.en) begin
            r0_v <= i_flow.valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            if (r1_v) begin
                r_fwd_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r0_idx   <= i_idx;
            r0_samps <= i_samps;
            r0_first <= i_first;
            r0_frame <= i_frame;
            r0_limit <= SUM_W'(i_frame) * LIM_MUL;
            r0_q     <= w_prod[47:32];
            r1_idx   <= r0_idx;
            r1_samps <= r0_samps;
            r1_first <= r0_first;
            r1_frame <= r0_frame;
            r1_limit <= r0_limit;
            r1_addr  <= w_addr;
            r_rd     <= r_mem[w_addr];
            r2_idx   <= r1_idx;
            r2_frame <= r1_frame;
            r2_limit <= r1_limit;
            r2_sums  <= n_sums;
            if (r1_v) begin
                r_mem[r1_addr] <= n_sums;
                r_fwd_addr     <= r1_addr;
                r_fwd_sums     <= n_sums;
            end
        end
    end

    assign o_valid = r2_v;
    assign o_idx   = r2_idx;
    assign o_frame = r2_frame;
    assign o_limit = r2_limit;
    assign o_sums  = r2_sums;
endmodule

FILE: design/ppa_div.sv
// Pipelined restoring divider: one quotient bit per stage, with clamp detection.
module ppa_div import ppa_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_flow                             i_flow,
    input  logic [IDX_W-1:0]                  i_idx,
    input  logic [FRAME_BITS-1:0]             i_frame,
    input  logic [SUM_W-1:0]                  i_limit,
    input  t_sums                             i_sums,
    output logic                              o_valid,
    output logic [IDX_W-1:0]                  o_idx,
    output logic [CH-1:0]                     o_clamp,
    output logic [CH-1:0][FRAC_BITS:0]        o_quot
);
    localparam int N = FRAC_BITS + 1;

    logic                              r_v     [N+1];
    logic [IDX_W-1:0]                  r_idx   [N+1];
    logic [FRAME_BITS-1:0]             r_frame [N+1];
    logic [CH-1:0]                     r_clamp [N+1];
    logic [CH-1:0][SUM_W-1:0]          r_rem   [N+1];
    logic [CH-1:0][N-1:0]              r_quot  [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_flow.en) begin
            r_v[0] <= i_flow.valid;
        end
    end

    // A sum at or above frame times (1.0 + lsb) averages to more than 1.0.
    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r_idx[0]   <= i_idx;
            r_frame[0] <= i_frame;
            for (int c = 0; c < CH; c++) begin
                r_clamp[0][c] <= (i_sums[c] >= i_limit);
                r_rem[0][c]   <= i_sums[c];
                r_quot[0][c]  <= '0;
            end
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_step
        localparam int BIT = N - 1 - s;
        logic [SUM_W:0] w_div;
        logic [CH-1:0][SUM_W-1:0] n_rem;
        logic [CH-1:0][N-1:0]     n_quot;

        assign w_div = (SUM_W+1)'(r_frame[s]) << BIT;

        always_comb begin
            for (int c = 0; c < CH; c++) begin
                n_rem[c]  = r_rem[s][c];
                n_quot[c] = r_quot[s][c];
                if ((SUM_W+1)'(r_rem[s][c]) >= w_div) begin
                    n_rem[c]       = r_rem[s][c] - w_div[SUM_W-1:0];
                    n_quot[c][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_flow.en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_idx[s+1]   <= r_idx[s];
                r_frame[s+1] <= r_frame[s];
                r_clamp[s+1] <= r_clamp[s];
                r_rem[s+1]   <= n_rem;
                r_quot[s+1]  <= n_quot;
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_idx   = r_idx[N];
    assign o_clamp = r_clamp[N];
    assign o_quot  = r_quot[N];
endmodule
